[rtl/lfps_pkg.sv]
`default_nettype none
package lfps_pkg;

   // field and datapath widths
   localparam int PatW   = 5;
   localparam int SpeedW = 15;
   localparam int ErrW   = 12;
   localparam int DerivW = ErrW + 1;
   localparam int SumW   = 25;
   localparam int DriveW = 16;
   localparam int OpAW   = 16;
   localparam int OpBW   = 26;
   localparam int ProdW  = 43;
   localparam int Q10_SHIFT = 10;
   localparam int CorrW  = ProdW - Q10_SHIFT;
   localparam int IntegShift = 9;
   localparam int CsrIdxW = 3;

   // floor(x/3) = (x * 43691) >> 17 for any x below 2^16
   localparam logic [OpAW-1:0] THIRD_RECIP = 16'd43691;
   localparam int THIRD_SHIFT = 17;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_SPEED_LIM  = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_SPIN_SPEED = 3'd4;

   // special sensor patterns
   localparam logic [PatW-1:0] PAT_LEFT_ONE  = 5'h01;
   localparam logic [PatW-1:0] PAT_LEFT_TWO  = 5'h03;
   localparam logic [PatW-1:0] PAT_RIGHT_ONE = 5'h10;
   localparam logic [PatW-1:0] PAT_RIGHT_TWO = 5'h18;
   localparam logic [PatW-1:0] PAT_ALL_ON    = 5'h1F;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_THIRD,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SCALE,
      ST_FINISH
   } seq_state_type;

   // control word for the shared multiply-accumulate unit
   typedef struct packed {
      logic                   load;
      logic                   accum;
      logic [OpAW-1:0]        op_a;
      logic signed [OpBW-1:0] op_b;
   } mul_ctrl_type;

   // active bits form at most one run: adding the lowest set bit clears the whole run
   function automatic logic run_contiguous(input logic [PatW-1:0] p);
      logic [PatW:0] ext;
      logic [PatW:0] low;
      logic [PatW:0] sum;
      ext = {1'b0, p};
      low = ext & (~ext + 1'b1);
      sum = ext + low;
      return (sum & ext) == '0;
   endfunction

   // truncated mean of the active sensor weights, contiguous patterns only
   function automatic logic signed [ErrW-1:0] line_position(input logic [PatW-1:0] p);
      logic signed [ErrW-1:0] pos;
      unique case (p)
         5'h01:   pos = -12'sd2000;
         5'h02:   pos = -12'sd1000;
         5'h04:   pos = 12'sd0;
         5'h08:   pos = 12'sd1000;
         5'h10:   pos = 12'sd2000;
         5'h03:   pos = -12'sd1500;
         5'h06:   pos = -12'sd500;
         5'h0C:   pos = 12'sd500;
         5'h18:   pos = 12'sd1500;
         5'h07:   pos = -12'sd1000;
         5'h0E:   pos = 12'sd0;
         5'h1C:   pos = 12'sd1000;
         5'h0F:   pos = -12'sd500;
         5'h1E:   pos = 12'sd500;
         5'h1F:   pos = 12'sd0;
         default: pos = 12'sd0;
      endcase
      return pos;
   endfunction

endpackage
`default_nettype wire

[rtl/lfps_mul_unit.sv]
`default_nettype none
module lfps_mul_unit (
   input  wire logic                               clock,
   input  wire lfps_pkg::mul_ctrl_type             ctrl,
   output logic signed [lfps_pkg::ProdW-1:0]       acc
);
   import lfps_pkg::*;

   logic signed [ProdW-1:0] prod;
   logic signed [ProdW-1:0] acc_ff;
   logic signed [ProdW-1:0] acc_in;

   // unsigned gain times signed operand, both sign-correct at full width
   assign prod = $signed({{(ProdW-OpAW){1'b0}}, ctrl.op_a})
               * $signed({{(ProdW-OpBW){ctrl.op_b[OpBW-1]}}, ctrl.op_b});

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = prod;
      end else if (ctrl.accum) begin
         acc_in = acc_ff + prod;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule
`default_nettype wire

[rtl/line_follow_pid_steering_core.sv]
`default_nettype none
// Five-sensor line follower with PID steering. Each req transfer carries a
// five-bit sensor pattern and a cruise speed; each rsp transfer returns the
// left and right wheel commands, the line offset and two status flags. A
// non-contiguous pattern falls back to the last accepted pattern while the
// line is seen. With the line lost the wheels spin toward the side of the last
// error; otherwise a Q10 PID correction is added to the left wheel and
// taken from the right, both clamped to 0..speed_limit, and edge or all-on
// patterns override the speeds. From req transfer to a loaded rsp register:
// the pattern is decoded and the integral updated as the transfer is taken,
// then four passes through the single shared 16x26 multiply-accumulate unit
// (cruise/3, then the P, I and D terms), one Q10 scaling step and a final
// step to clamp and load the result, which waits while a held result is not
// taken. A new sample is taken only after the sequencer is back in idle.
// req_tready is high only while the sequencer is idle; it does not wait for
// a pending result to be taken, the output register holds it until
// rsp_tready.
module line_follow_pid_steering_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // config write port
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_wdata,
   // sample stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // sensor_pattern[4:0], cruise_speed[19:5], zero pad
   // result stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // left_drive[15:0], right_drive[31:16],
                                         // line_offset[43:32], line_found[44],
                                         // pattern_ok[45], zero pad
);
   import lfps_pkg::*;

   // configuration registers
   logic [SpeedW-1:0] prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic [SpeedW-1:0] speed_lim_ff, spin_speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= '0;
         integ_gain_ff <= '0;
         deriv_gain_ff <= '0;
         speed_lim_ff  <= '0;
         spin_speed_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_INTEG_GAIN: integ_gain_ff <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            CSR_SPEED_LIM:  speed_lim_ff  <= csr_wdata;
            CSR_SPIN_SPEED: spin_speed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   seq_state_type state_ff, state_in;
   logic          take_req;
   logic          finish_fire;
   mul_ctrl_type  mul_ctrl;
   logic signed [ProdW-1:0] mul_acc;

   // loop state
   logic [PatW-1:0]        held_pat_ff, held_pat_in;
   logic                   seen_ff, seen_in;
   logic signed [ErrW-1:0] prev_err_ff, prev_err_in;
   logic signed [SumW-1:0] err_sum_ff, err_sum_in;
   logic signed [ErrW-1:0] offset_ff, offset_in;

   // per-sample working registers
   logic [PatW-1:0]          pat_ff, pat_in;
   logic [SpeedW-1:0]        cruise_ff, cruise_in;
   logic signed [ErrW-1:0]   err_ff, err_in;
   logic signed [DerivW-1:0] deriv_ff, deriv_in;
   logic signed [SumW-1:0]   isum_ff, isum_in;
   logic                     found_ff, found_in;
   logic                     ok_ff, ok_in;
   logic                     spin_neg_ff, spin_neg_in;
   logic [SpeedW-1:0]        third_ff, third_in;
   logic signed [CorrW-1:0]  corr_ff, corr_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   // decode of the incoming pattern
   logic [PatW-1:0]          raw_pat;
   logic [PatW-1:0]          use_pat;
   logic                     raw_ok;
   logic signed [ErrW-1:0]   new_err;
   logic signed [SumW:0]     isum_raw;
   logic signed [SumW:0]     isum_max;
   logic signed [SumW-1:0]   isum_clamped;

   always_comb begin
      raw_pat  = req_tdata[PatW-1:0];
      raw_ok   = run_contiguous(raw_pat);
      use_pat  = raw_ok ? raw_pat : (seen_ff ? held_pat_ff : '0);
      new_err  = line_position(use_pat);
      isum_raw = (SumW+1)'(err_sum_ff) + (SumW+1)'(new_err);
      isum_max = $signed({{(SumW+1-SpeedW-IntegShift){1'b0}}, speed_lim_ff,
                          {IntegShift{1'b0}}});
      if (isum_raw > isum_max) begin
         isum_clamped = SumW'(isum_max);
      end else if (isum_raw < -isum_max) begin
         isum_clamped = SumW'(-isum_max);
      end else begin
         isum_clamped = SumW'(isum_raw);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_MUL_THIRD;
         ST_MUL_THIRD: state_in = ST_MUL_P;
         ST_MUL_P:     state_in = ST_MUL_I;
         ST_MUL_I:     state_in = ST_MUL_D;
         ST_MUL_D:     state_in = ST_SCALE;
         ST_SCALE:     state_in = ST_FINISH;
         ST_FINISH:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs: handshake and multiplier control
   always_comb begin
      req_tready     = 1'b0;
      finish_fire    = 1'b0;
      mul_ctrl.load  = 1'b0;
      mul_ctrl.accum = 1'b0;
      mul_ctrl.op_a  = '0;
      mul_ctrl.op_b  = '0;
      unique case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_MUL_THIRD: begin
            mul_ctrl.load = 1'b1;
            mul_ctrl.op_a = THIRD_RECIP;
            mul_ctrl.op_b = $signed({{(OpBW-SpeedW){1'b0}}, cruise_ff});
         end
         ST_MUL_P: begin
            mul_ctrl.load = 1'b1;
            mul_ctrl.op_a = {1'b0, prop_gain_ff};
            mul_ctrl.op_b = OpBW'(err_ff);
         end
         ST_MUL_I: begin
            mul_ctrl.accum = 1'b1;
            mul_ctrl.op_a  = {1'b0, integ_gain_ff};
            mul_ctrl.op_b  = OpBW'(isum_ff);
         end
         ST_MUL_D: begin
            mul_ctrl.accum = 1'b1;
            mul_ctrl.op_a  = {1'b0, deriv_gain_ff};
            mul_ctrl.op_b  = OpBW'(deriv_ff);
         end
         ST_SCALE: ;
         ST_FINISH: finish_fire = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign take_req = req_tvalid && req_tready;

   lfps_mul_unit u_mul (
      .clock (clock),
      .ctrl  (mul_ctrl),
      .acc   (mul_acc)
   );

   // loop state and sample capture at the req transfer
   always_comb begin
      held_pat_in = held_pat_ff;
      seen_in     = seen_ff;
      prev_err_in = prev_err_ff;
      err_sum_in  = err_sum_ff;
      offset_in   = offset_ff;
      pat_in      = pat_ff;
      cruise_in   = cruise_ff;
      err_in      = err_ff;
      deriv_in    = deriv_ff;
      isum_in     = isum_ff;
      found_in    = found_ff;
      ok_in       = ok_ff;
      spin_neg_in = spin_neg_ff;
      if (take_req) begin
         held_pat_in = use_pat;
         pat_in      = use_pat;
         cruise_in   = req_tdata[PatW +: SpeedW];
         err_in      = new_err;
         deriv_in    = DerivW'(new_err) - DerivW'(prev_err_ff);
         isum_in     = isum_clamped;
         found_in    = use_pat != '0;
         ok_in       = raw_ok;
         // lost line spins toward the side of the last error
         spin_neg_in = prev_err_ff[ErrW-1];
         seen_in     = use_pat != '0;
         if (use_pat != '0) begin
            prev_err_in = new_err;
            err_sum_in  = isum_clamped;
            offset_in   = new_err;
         end
      end
   end

   // cruise/3 sits in the accumulator in the cycle after its pass
   always_comb begin
      third_in = third_ff;
      if (state_ff == ST_MUL_P) begin
         third_in = mul_acc[THIRD_SHIFT +: SpeedW];
      end
   end

   // q10 scaling with truncation toward zero
   logic signed [ProdW-1:0] corr_biased;
   always_comb begin
      corr_biased = mul_acc + (mul_acc[ProdW-1] ? ProdW'((1 << Q10_SHIFT) - 1) : ProdW'(0));
      corr_in     = corr_ff;
      if (state_ff == ST_SCALE) begin
         corr_in = corr_biased[ProdW-1:Q10_SHIFT];
      end
   end

   // wheel commands
   logic signed [CorrW:0]  left_sum, right_sum;
   logic signed [CorrW:0]  cruise_ext, lim_ext;
   logic [SpeedW-1:0]      left_pid, right_pid;
   logic [DriveW-1:0]      left_cmd, right_cmd;
   logic [DriveW-1:0]      spin_pos, spin_neg;

   always_comb begin
      cruise_ext = $signed({{(CorrW+1-SpeedW){1'b0}}, cruise_ff});
      lim_ext    = $signed({{(CorrW+1-SpeedW){1'b0}}, speed_lim_ff});
      left_sum   = cruise_ext + (CorrW+1)'(corr_ff);
      right_sum  = cruise_ext - (CorrW+1)'(corr_ff);

      if (left_sum[CorrW]) begin
         left_pid = '0;
      end else if (left_sum > lim_ext) begin
         left_pid = speed_lim_ff;
      end else begin
         left_pid = left_sum[SpeedW-1:0];
      end
      if (right_sum[CorrW]) begin
         right_pid = '0;
      end else if (right_sum > lim_ext) begin
         right_pid = speed_lim_ff;
      end else begin
         right_pid = right_sum[SpeedW-1:0];
      end

      spin_pos = {1'b0, spin_speed_ff};
      spin_neg = -spin_pos;

      if (!found_ff) begin
         left_cmd  = spin_neg_ff ? spin_neg : spin_pos;
         right_cmd = spin_neg_ff ? spin_pos : spin_neg;
      end else if (pat_ff == PAT_LEFT_ONE || pat_ff == PAT_LEFT_TWO) begin
         // line at the left edge: hard turn left
         left_cmd  = {1'b0, third_ff};
         right_cmd = {1'b0, speed_lim_ff};
      end else if (pat_ff == PAT_RIGHT_ONE || pat_ff == PAT_RIGHT_TWO) begin
         // line at the right edge: hard turn right
         left_cmd  = {1'b0, speed_lim_ff};
         right_cmd = {1'b0, third_ff};
      end else if (pat_ff == PAT_ALL_ON) begin
         // crossing or stop bar: half cruise straight
         left_cmd  = {2'b00, cruise_ff[SpeedW-1:1]};
         right_cmd = {2'b00, cruise_ff[SpeedW-1:1]};
      end else begin
         left_cmd  = {1'b0, left_pid};
         right_cmd = {1'b0, right_pid};
      end
   end

   // result register, loaded when the previous result is gone or leaving
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00, ok_ff, found_ff, offset_ff, right_cmd, left_cmd};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         held_pat_ff  <= '0;
         seen_ff      <= 1'b0;
         prev_err_ff  <= '0;
         err_sum_ff   <= '0;
         offset_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         held_pat_ff  <= held_pat_in;
         seen_ff      <= seen_in;
         prev_err_ff  <= prev_err_in;
         err_sum_ff   <= err_sum_in;
         offset_ff    <= offset_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pat_ff      <= pat_in;
      cruise_ff   <= cruise_in;
      err_ff      <= err_in;
      deriv_ff    <= deriv_in;
      isum_ff     <= isum_in;
      found_ff    <= found_in;
      ok_ff       <= ok_in;
      spin_neg_ff <= spin_neg_in;
      third_ff    <= third_in;
      corr_ff     <= corr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

[verif/line_follow_pid_steering_core_test.sv]
`default_nettype none
module line_follow_pid_steering_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   import lfps_pkg::*;

   // run limits: cycle budget, and settle time once nothing is outstanding
   localparam int CYCLE_LIMIT   = 250000;
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_PERCENT  = 24;

   // csr indexes past the last mapped register, writes there must be dropped
   localparam logic [CsrIdxW-1:0] CSR_UNMAPPED_LOW  = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   localparam logic [SpeedW-1:0] SPEED_MAX = 15'h7FFF;

   // one wheel command as packed on rsp_tdata, lowest field last here
   typedef struct packed {
      logic                     pattern_ok;
      logic                     line_found;
      logic signed [ErrW-1:0]   line_offset;
      logic signed [DriveW-1:0] right_drive;
      logic signed [DriveW-1:0] left_drive;
   } drive_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [14:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // sensor_pattern[4:0], cruise_speed[19:5], zero pad
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // left_drive[15:0], right_drive[31:16],
                                  // line_offset[43:32], line_found[44],
                                  // pattern_ok[45], zero pad

   // shadow of the csr registers as the steering predictor sees them
   longint prop_k;
   longint integ_k;
   longint deriv_k;
   longint speed_cap;
   longint spin_speed;

   // shadow of the controller state
   logic [PatW-1:0] held_bits;
   bit              seen_shadow;
   longint          prev_err_shadow;
   longint          error_integral;
   longint          held_offset;

   drive_cmd_type pending_drives[$];   // predicted commands, oldest first
   int            mismatch_count;
   int            cycle_count;
   bit            idle_on;             // random idling on both streams
   int            rsp_hold_cycles;     // long receiver hold-off, counted down below

   line_follow_pid_steering_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // steering predictor
   // ---------------------------------------------------------------------

   // true when the active bits form at most one run
   function automatic bit single_run(logic [PatW-1:0] p);
      logic [PatW:0] shifted;
      int            starts;
      shifted = {p, 1'b0};
      starts  = 0;
      for (int i = 0; i < PatW; i++)
         if (shifted[i+1] && !shifted[i]) starts++;
      return starts <= 1;
   endfunction

   function automatic longint clamp_wheel(longint v);
      if (v < 0) return 0;
      if (v > speed_cap) return speed_cap;
      return v;
   endfunction

   // advances the shadow state by one sample and returns the wheel command
   function automatic drive_cmd_type predict_steering(logic [PatW-1:0] raw,
                                                      logic [SpeedW-1:0] cruise);
      drive_cmd_type   cmd;
      logic [PatW-1:0] used;
      bit              ok;
      longint          wsum, cnt, err, deriv, isum, imax, corr, lft, rgt, cr;
      ok   = single_run(raw);
      // broken pattern: fall back to the held one only while the line is seen
      used = ok ? raw : (seen_shadow ? held_bits : '0);
      held_bits = used;
      cr   = cruise;
      wsum = 0;
      cnt  = 0;
      // sensor weights run -2000..2000 in steps of 1000, far left first
      for (int i = 0; i < PatW; i++)
         if (used[i]) begin
            wsum += (i - 2) * 1000;
            cnt++;
         end
      if (cnt == 0) begin
         // line lost: spin toward the side of the last error, state kept
         seen_shadow = 1'b0;
         if (prev_err_shadow >= 0) begin
            lft = spin_speed;
            rgt = -spin_speed;
         end else begin
            lft = -spin_speed;
            rgt = spin_speed;
         end
      end else begin
         err   = wsum / cnt;                 // truncates toward zero
         deriv = err - prev_err_shadow;
         isum  = error_integral + err;
         imax  = speed_cap * 512;
         if (isum > imax) isum = imax;
         else if (isum < -imax) isum = -imax;
         error_integral = isum;
         corr = (prop_k * err + integ_k * isum + deriv_k * deriv) / 1024;
         prev_err_shadow = err;
         held_offset     = err;
         seen_shadow     = 1'b1;
         lft = clamp_wheel(cr + corr);
         rgt = clamp_wheel(cr - corr);
         // edge and all-on patterns override the pid speeds
         if (used == PAT_LEFT_ONE || used == PAT_LEFT_TWO) begin
            lft = cr / 3;
            rgt = speed_cap;
         end else if (used == PAT_RIGHT_ONE || used == PAT_RIGHT_TWO) begin
            lft = speed_cap;
            rgt = cr / 3;
         end else if (used == PAT_ALL_ON) begin
            lft = cr / 2;
            rgt = cr / 2;
         end
      end
      cmd.left_drive  = lft[DriveW-1:0];
      cmd.right_drive = rgt[DriveW-1:0];
      cmd.line_offset = held_offset[ErrW-1:0];
      cmd.line_found  = (cnt != 0);
      cmd.pattern_ok  = ok;
      return cmd;
   endfunction

   // ---------------------------------------------------------------------
   // result side: receiver ready and checker
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold_cycles <= rsp_hold_cycles - 1;
      end else if (idle_on) begin
         rsp_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(string what, longint want, longint got);
      if (want != got) begin
         $display("%0t ERROR %s expected %0d actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      drive_cmd_type want;
      drive_cmd_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[45:0];
         if (pending_drives.size() == 0) begin
            $display("%0t ERROR unexpected transfer expected none actual %h",
                     $time, rsp_tdata);
            mismatch_count++;
         end else if ($isunknown(rsp_tdata)) begin
            want = pending_drives.pop_front();
            $display("%0t ERROR unknown bits expected %h actual %h",
                     $time, want, rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_drives.pop_front();
            check_field("left_drive", want.left_drive, got.left_drive);
            check_field("right_drive", want.right_drive, got.right_drive);
            check_field("line_offset", want.line_offset, got.line_offset);
            check_field("line_found", want.line_found, got.line_found);
            check_field("pattern_ok", want.pattern_ok, got.pattern_ok);
            check_field("zero pad", 0, rsp_tdata[47:46]);
         end
      end
   end

   // ---------------------------------------------------------------------
   // sample side
   // ---------------------------------------------------------------------

   // offers one sample and predicts its command once the transfer happens
   task automatic send_sample(logic [PatW-1:0] pattern, logic [SpeedW-1:0] cruise);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, cruise, pattern};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_drives.push_back(predict_steering(pattern, cruise));
   endtask

   // drops valid and waits until every command is back and the core has settled
   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [SpeedW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PROP_GAIN:  prop_k     = value;
         CSR_INTEG_GAIN: integ_k    = value;
         CSR_DERIV_GAIN: deriv_k    = value;
         CSR_SPEED_LIM:  speed_cap  = value;
         CSR_SPIN_SPEED: spin_speed = value;
         default: ;
      endcase
   endtask

   // full register set, with a stray write to an unmapped index in between
   task automatic apply_setting(logic [SpeedW-1:0] kp, logic [SpeedW-1:0] ki,
                                logic [SpeedW-1:0] kd, logic [SpeedW-1:0] cap,
                                logic [SpeedW-1:0] spin);
      logic [CsrIdxW-1:0] stray;
      wait_quiet();
      stray = CsrIdxW'($urandom_range(CSR_UNMAPPED_LOW, CSR_UNMAPPED_HIGH));
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
      write_csr(stray, 15'($urandom));
      write_csr(CSR_DERIV_GAIN, kd);
      write_csr(CSR_SPEED_LIM, cap);
      write_csr(CSR_SPIN_SPEED, spin);
   endtask

   // mostly one contiguous run, some lost-line samples, some broken patterns
   function automatic logic [PatW-1:0] pick_pattern();
      int roll, len, start;
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         len   = $urandom_range(1, PatW);
         start = $urandom_range(0, PatW - len);
         return PatW'(((1 << len) - 1) << start);
      end
      if (roll < 80) return '0;
      return PatW'($urandom);
   endfunction

   function automatic logic [SpeedW-1:0] pick_cruise();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return '0;
      if (roll < 16) return SPEED_MAX;
      if (roll < 40) return SpeedW'($urandom_range(0, 255));
      return SpeedW'($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // moderate gains used by the directed samples, plus unmapped writes
   task automatic test_register_writes();
      write_csr(CSR_UNMAPPED_LOW, SPEED_MAX);
      apply_setting(15'd1024, 15'd64, 15'd512, 15'd20000, 15'd3000);
      write_csr(CSR_UNMAPPED_HIGH, SPEED_MAX);
   endtask

   task automatic test_directed_samples();
      send_sample(5'h00, 15'd12000);    // empty from reset, zero error spins right
      send_sample(5'h0A, 15'd12000);    // broken pattern with no line seen
      send_sample(5'h04, SPEED_MAX);    // centered, top cruise
      send_sample(5'h01, SPEED_MAX);    // left edge, one sensor
      send_sample(5'h03, 15'd0);        // left edge, two sensors
      send_sample(5'h10, SPEED_MAX);    // right edge, one sensor
      send_sample(5'h18, 15'd100);      // right edge, two sensors
      send_sample(5'h1F, SPEED_MAX);    // all on
      send_sample(5'h1F, 15'd0);
      send_sample(5'h05, 15'd9000);     // broken, held all-on reused
      send_sample(5'h02, 15'd15000);    // negative error
      send_sample(5'h00, 15'd15000);    // lost after negative error, spin left
      send_sample(5'h11, 15'd15000);    // broken with line lost
      send_sample(5'h08, 15'd15000);    // positive error
      send_sample(5'h14, 15'd15000);    // broken, held pattern reused
      send_sample(5'h00, 15'd15000);    // lost after positive error
      send_sample(5'h06, 15'd20000);
      send_sample(5'h0C, 15'd25000);
      send_sample(5'h07, 15'd1);
      send_sample(5'h0E, 15'd2);
      send_sample(5'h1C, 15'd32766);
      send_sample(5'h0F, 15'd16384);
      send_sample(5'h1E, 15'd8191);
      send_sample(5'h1B, 15'd5000);
      send_sample(5'h0D, 15'd5555);
   endtask

   // receiver holds off while the sender keeps offering, so req stalls
   task automatic test_output_backpressure();
      wait_quiet();
      @(posedge clock);
      idle_on = 1'b0;
      rsp_hold_cycles = 300;
      repeat (8) send_sample(pick_pattern(), pick_cruise());
      wait_quiet();
      idle_on = 1'b1;
   endtask

   // sender drains completely between two bursts
   task automatic test_sender_pause();
      repeat (20) send_sample(pick_pattern(), pick_cruise());
      wait_quiet();
      repeat (20) send_sample(pick_pattern(), pick_cruise());
   endtask

   // random samples under several register settings, extremes included
   task automatic test_random_settings();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_setting(SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX, SPEED_MAX);
            1: apply_setting('0, '0, '0, '0, '0);
            2: apply_setting(15'($urandom_range(256, 4096)), 15'($urandom_range(0, 256)),
                             15'($urandom_range(0, 2048)),
                             15'($urandom_range(4000, 32767)), 15'($urandom));
            // tiny speed cap keeps the integral on its clamp
            3: apply_setting(15'($urandom), 15'($urandom), 15'($urandom),
                             15'($urandom_range(0, 40)), 15'($urandom_range(0, 40)));
            4: apply_setting(15'($urandom), 15'($urandom), 15'($urandom),
                             15'($urandom), 15'($urandom));
            default: apply_setting('0, SPEED_MAX, '0, SPEED_MAX, 15'($urandom));
         endcase
         // one phase runs with both streams saturated
         idle_on = (ph != 2);
         repeat (150) send_sample(pick_pattern(), pick_cruise());
      end
      idle_on = 1'b1;
   endtask

   initial begin
      prop_k          = 0;
      integ_k         = 0;
      deriv_k         = 0;
      speed_cap       = 0;
      spin_speed      = 0;
      held_bits       = '0;
      seen_shadow     = 1'b0;
      prev_err_shadow = 0;
      error_integral  = 0;
      held_offset     = 0;
      mismatch_count  = 0;
      cycle_count     = 0;
      rsp_hold_cycles = 0;
      idle_on         = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_register_writes();
      test_directed_samples();
      test_output_backpressure();
      test_sender_pause();
      test_random_settings();

      wait_quiet();
      if (mismatch_count == 0 && pending_drives.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

[files.f]
rtl/lfps_pkg.sv
rtl/lfps_mul_unit.sv
rtl/line_follow_pid_steering_core.sv
verif/line_follow_pid_steering_core_test.sv
